FILE: rtl/cbfp_pkg.sv
// ============================================================================
// cbfp_pkg: shared types and constants of the content box fit placer
// Field widths, register indexes, anchor codes and divider sizing.
// ============================================================================
`default_nettype none

package cbfp_pkg;

  // Largest frame dimension that the row and column counters cover.
  localparam int unsigned MAX_DIM = 4096;

  localparam int unsigned CNT_W   = 12;   // row and column counters
  localparam int unsigned DIM_W   = 13;   // frame, canvas and fit sizes
  localparam int unsigned CHAN_W  = 8;    // one colour channel
  localparam int unsigned MARG_W  = 11;   // margin register
  localparam int unsigned MODE_W  = 4;    // anchor code
  localparam int unsigned CFG_W   = 13;   // widest register
  localparam int unsigned IDX_W   = 3;    // register index
  localparam int unsigned AREA_W  = DIM_W + 2;       // signed usable size
  localparam int unsigned PROD_W  = 2 * DIM_W;       // fit product
  localparam int unsigned DIV_STEPS = PROD_W;        // one quotient bit a step
  localparam int unsigned STEP_W  = $clog2(DIV_STEPS);
  localparam int unsigned IN_W    = 24;
  localparam int unsigned OUT_W   = 104;

  typedef enum logic [IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_THRESHOLD    = 3'd2,
    REG_TARGET_WIDTH = 3'd3,
    REG_TARGET_HEIGHT = 3'd4,
    REG_MARGIN       = 3'd5,
    REG_PLACE_MODE   = 3'd6
  } reg_index_t;

  // Anchor codes; every other value places the core in the centre.
  localparam logic [MODE_W-1:0] PLACE_TOP          = 4'd2;
  localparam logic [MODE_W-1:0] PLACE_BOTTOM       = 4'd3;
  localparam logic [MODE_W-1:0] PLACE_LEFT         = 4'd4;
  localparam logic [MODE_W-1:0] PLACE_RIGHT        = 4'd5;
  localparam logic [MODE_W-1:0] PLACE_TOP_LEFT     = 4'd6;
  localparam logic [MODE_W-1:0] PLACE_TOP_RIGHT    = 4'd7;
  localparam logic [MODE_W-1:0] PLACE_BOTTOM_LEFT  = 4'd8;
  localparam logic [MODE_W-1:0] PLACE_BOTTOM_RIGHT = 4'd9;

  localparam logic [DIM_W-1:0] MAX_DIM_VAL = DIM_W'(MAX_DIM);

  // A frame size of zero counts as one, a size beyond the maximum as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > MAX_DIM_VAL) begin
      r = MAX_DIM_VAL;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] r;
    if (a > b) begin
      r = a - b;
    end else begin
      r = b - a;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/content_bbox_fit_placer.sv
// ============================================================================
// content_bbox_fit_placer: content bounding box and aspect fit of a frame
// Scans a frame's pixels for content, then fits and places the content box
// on an output canvas with one shared multiplier and one serial divider.
// ============================================================================
// Usage:
//  Pixels enter on the s_ group in raster order, one request per pixel, with
//  chan0 in s_tdata[7:0], chan1 in [15:8] and chan2 in [23:16]. Every pixel
//  but the last of a frame is taken without a stall, so a frame streams at one
//  pixel per clock. The first pixel of a frame sets the background colour.
//  On the last pixel the block stops taking requests (s_tready low) and runs
//  its fit sequence: setup, a 13x13 multiply, a 26-step restoring division
//  that yields one quotient bit a cycle, and a check. When the first quotient
//  overflows the usable area the multiply and divide run a second time.
//  Placement then loads the output register and raises m_tvalid; a degenerate
//  box goes from setup straight to placement. The result is held in an output
//  register on the m_ group until taken. If the receiver stalls, the next
//  frame still streams in; only the next frame's placement waits for the
//  register to drain. Configuration writes on cfg_wr_en/cfg_index/cfg_data
//  are to be made while the block is idle; the block itself does not enforce
//  this. Synchronous reset restores the register defaults, clears the frame
//  scan and drops m_tvalid.
`default_nettype none

module content_bbox_fit_placer (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Configuration write port.
  input  wire logic                         cfg_wr_en,
  input  wire logic [cbfp_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [cbfp_pkg::CFG_W-1:0]   cfg_data,
  // Pixel stream. s_tdata from bit 0: chan0, chan1, chan2.
  input  wire logic                         s_tvalid,
  output      logic                         s_tready,
  input  wire logic [cbfp_pkg::IN_W-1:0]    s_tdata,
  // Result stream. m_tdata from bit 0: top_row, left_col, right_col,
  // bottom_row, fit_width, fit_height, place_x, place_y, two zero bits.
  // m_tuser: status.
  output      logic                         m_tvalid,
  input  wire logic                         m_tready,
  output      logic [cbfp_pkg::OUT_W-1:0]   m_tdata,
  output      logic                         m_tuser
);

  typedef enum logic [2:0] {
    S_PIX,     // scanning pixels
    S_PREP,    // core and usable sizes, degenerate check
    S_MUL,     // shared multiplier
    S_DIV,     // serial divider
    S_CHECK,   // compare quotient with the usable area
    S_PLACE    // anchor and load the output register
  } state_t;

  state_t state;

  // Configuration registers.
  logic [cbfp_pkg::DIM_W-1:0]  frame_width, frame_height;
  logic [cbfp_pkg::CHAN_W-1:0] color_threshold;
  logic [cbfp_pkg::DIM_W-1:0]  target_width, target_height;
  logic [cbfp_pkg::MARG_W-1:0] margin;
  logic [cbfp_pkg::MODE_W-1:0] place_mode;

  // Frame scan state.
  logic [cbfp_pkg::IN_W-1:0]   background;
  logic [cbfp_pkg::CNT_W-1:0]  row_count, col_count;
  logic [cbfp_pkg::CNT_W-1:0]  min_row, max_row, min_col, max_col;
  logic                        content_seen;

  // Box captured at the end of a frame.
  logic [cbfp_pkg::CNT_W-1:0]  box_top, box_left;
  logic [cbfp_pkg::DIM_W-1:0]  box_right, box_bottom;

  // Fit sequence state.
  logic [cbfp_pkg::DIM_W-1:0]  core_w, core_h, area_w, area_h;
  logic                        tall, second, degen;
  logic [cbfp_pkg::DIM_W-1:0]  fit_w, fit_h;
  logic [cbfp_pkg::DIM_W-1:0]  divisor;
  logic [cbfp_pkg::DIM_W-1:0]  rem;
  logic [cbfp_pkg::PROD_W-1:0] quo;
  logic [cbfp_pkg::STEP_W-1:0] step;

  // ---------------------------------------------------------------------------
  // Pixel datapath.
  // ---------------------------------------------------------------------------
  logic [cbfp_pkg::DIM_W-1:0]  w_eff, h_eff;
  logic                        first_pix, content, row_end, frame_end, pix_acc;
  logic [cbfp_pkg::IN_W-1:0]   bg_cur;
  logic [cbfp_pkg::CNT_W-1:0]  min_row_next, max_row_next, min_col_next, max_col_next;
  logic                        seen_next;

  assign w_eff     = cbfp_pkg::clamp_dim(frame_width);
  assign h_eff     = cbfp_pkg::clamp_dim(frame_height);
  assign first_pix = (row_count == '0) && (col_count == '0);
  assign bg_cur    = first_pix ? s_tdata : background;
  assign row_end   = {1'b0, col_count} >= (w_eff - cbfp_pkg::DIM_W'(1));
  assign frame_end = row_end && ({1'b0, row_count} >= (h_eff - cbfp_pkg::DIM_W'(1)));
  assign s_tready  = (state == S_PIX);
  assign pix_acc   = s_tvalid && s_tready;

  // The background is stored with chan0 in the low byte, like the pixel.
  assign content =
    (cbfp_pkg::abs_diff(bg_cur[7:0],   s_tdata[7:0])   >= color_threshold) ||
    (cbfp_pkg::abs_diff(bg_cur[15:8],  s_tdata[15:8])  >= color_threshold) ||
    (cbfp_pkg::abs_diff(bg_cur[23:16], s_tdata[23:16]) >= color_threshold);

  always_comb begin
    min_row_next = min_row;
    max_row_next = max_row;
    min_col_next = min_col;
    max_col_next = max_col;
    seen_next    = content_seen;
    if (content) begin
      seen_next    = 1'b1;
      max_row_next = row_count;
      if (!content_seen) begin
        min_row_next = row_count;
      end
      if (!content_seen || (col_count < min_col)) begin
        min_col_next = col_count;
      end
      if (!content_seen || (col_count > max_col)) begin
        max_col_next = col_count;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Fit datapath: sizes, shared multiplier, divider step, placement.
  // ---------------------------------------------------------------------------
  logic signed [cbfp_pkg::AREA_W-1:0] aw_c, ah_c;
  logic [cbfp_pkg::DIM_W-1:0]  cw_c, ch_c;
  logic                        degen_c;

  assign cw_c = box_right - {1'b0, box_left};
  assign ch_c = box_bottom - {1'b0, box_top};
  assign aw_c = $signed({2'b00, target_width})
              - $signed({3'b000, margin, 1'b0});
  assign ah_c = $signed({2'b00, target_height})
              - $signed({3'b000, margin, 1'b0});
  assign degen_c = (cw_c == '0) || (ch_c == '0) || (aw_c <= 0) || (ah_c <= 0);

  // Which size the current pass produces: the width when the core is tall on
  // the first pass or wide or square on the second pass.
  logic                        calc_rw;
  logic [cbfp_pkg::DIM_W-1:0]  mul_a, mul_b;
  logic [cbfp_pkg::PROD_W-1:0] product;

  assign calc_rw = tall ^ second;
  assign mul_a   = calc_rw ? area_h : area_w;
  assign mul_b   = calc_rw ? core_w : core_h;
  assign product = mul_a * mul_b;

  logic [cbfp_pkg::DIM_W:0]    trial_rem;
  logic [cbfp_pkg::DIM_W:0]    trial_diff;
  logic                        trial_ok;

  assign trial_rem  = {rem, quo[cbfp_pkg::PROD_W-1]};
  assign trial_diff = trial_rem - {1'b0, divisor};
  assign trial_ok   = (trial_rem >= {1'b0, divisor});

  logic q_over_w, q_over_h;
  assign q_over_w = quo > cbfp_pkg::PROD_W'(area_w);
  assign q_over_h = quo > cbfp_pkg::PROD_W'(area_h);

  // Free space per axis, halved with truncation toward zero.
  logic signed [cbfp_pkg::AREA_W-1:0] sx, sy, hx, hy, px_off, py_off;
  logic [cbfp_pkg::AREA_W-1:0]        px_sum, py_sum;

  assign sx = $signed({2'b00, area_w}) - $signed({2'b00, fit_w});
  assign sy = $signed({2'b00, area_h}) - $signed({2'b00, fit_h});
  assign hx = (sx + $signed({{(cbfp_pkg::AREA_W-1){1'b0}}, sx[cbfp_pkg::AREA_W-1]})) >>> 1;
  assign hy = (sy + $signed({{(cbfp_pkg::AREA_W-1){1'b0}}, sy[cbfp_pkg::AREA_W-1]})) >>> 1;

  always_comb begin
    unique case (place_mode)
      cbfp_pkg::PLACE_TOP:          begin px_off = hx; py_off = '0; end
      cbfp_pkg::PLACE_BOTTOM:       begin px_off = hx; py_off = sy; end
      cbfp_pkg::PLACE_LEFT:         begin px_off = '0; py_off = hy; end
      cbfp_pkg::PLACE_RIGHT:        begin px_off = sx; py_off = hy; end
      cbfp_pkg::PLACE_TOP_LEFT:     begin px_off = '0; py_off = '0; end
      cbfp_pkg::PLACE_TOP_RIGHT:    begin px_off = sx; py_off = '0; end
      cbfp_pkg::PLACE_BOTTOM_LEFT:  begin px_off = '0; py_off = sy; end
      cbfp_pkg::PLACE_BOTTOM_RIGHT: begin px_off = sx; py_off = sy; end
      default:                      begin px_off = hx; py_off = hy; end
    endcase
  end

  assign px_sum = px_off + $signed({4'b0000, margin});
  assign py_sum = py_off + $signed({4'b0000, margin});

  // ---------------------------------------------------------------------------
  // Sequencer, scan registers and output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_PIX;
      frame_width     <= cbfp_pkg::DIM_W'(640);
      frame_height    <= cbfp_pkg::DIM_W'(480);
      color_threshold <= cbfp_pkg::CHAN_W'(10);
      target_width    <= cbfp_pkg::DIM_W'(300);
      target_height   <= cbfp_pkg::DIM_W'(200);
      margin          <= cbfp_pkg::MARG_W'(10);
      place_mode      <= cbfp_pkg::MODE_W'(1);
      background      <= '0;
      row_count       <= '0;
      col_count       <= '0;
      min_row         <= '0;
      max_row         <= '0;
      min_col         <= '1;
      max_col         <= '0;
      content_seen    <= 1'b0;
      second          <= 1'b0;
      step            <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          cbfp_pkg::REG_FRAME_WIDTH:   frame_width     <= cfg_data;
          cbfp_pkg::REG_FRAME_HEIGHT:  frame_height    <= cfg_data;
          cbfp_pkg::REG_THRESHOLD:     color_threshold <= cfg_data[cbfp_pkg::CHAN_W-1:0];
          cbfp_pkg::REG_TARGET_WIDTH:  target_width    <= cfg_data;
          cbfp_pkg::REG_TARGET_HEIGHT: target_height   <= cfg_data;
          cbfp_pkg::REG_MARGIN:        margin          <= cfg_data[cbfp_pkg::MARG_W-1:0];
          cbfp_pkg::REG_PLACE_MODE:    place_mode      <= cfg_data[cbfp_pkg::MODE_W-1:0];
          default: ;
        endcase
      end

      // In the placement state the load below decides m_tvalid on its own.
      if (m_tvalid && m_tready && (state != S_PLACE)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_PIX: begin
          if (pix_acc) begin
            background <= bg_cur;
            if (frame_end) begin
              box_top      <= seen_next ? min_row_next : '0;
              box_left     <= seen_next ? min_col_next : '0;
              box_right    <= seen_next ? {1'b0, max_col_next} : w_eff;
              box_bottom   <= seen_next ? {1'b0, max_row_next} : h_eff;
              row_count    <= '0;
              col_count    <= '0;
              min_row      <= '0;
              max_row      <= '0;
              min_col      <= '1;
              max_col      <= '0;
              content_seen <= 1'b0;
              state        <= S_PREP;
            end else begin
              min_row      <= min_row_next;
              max_row      <= max_row_next;
              min_col      <= min_col_next;
              max_col      <= max_col_next;
              content_seen <= seen_next;
              if (row_end) begin
                col_count <= '0;
                row_count <= row_count + cbfp_pkg::CNT_W'(1);
              end else begin
                col_count <= col_count + cbfp_pkg::CNT_W'(1);
              end
            end
          end
        end

        S_PREP: begin
          core_w <= cw_c;
          core_h <= ch_c;
          area_w <= aw_c[cbfp_pkg::DIM_W-1:0];
          area_h <= ah_c[cbfp_pkg::DIM_W-1:0];
          tall   <= ch_c > cw_c;
          second <= 1'b0;
          degen  <= degen_c;
          if (degen_c) begin
            fit_w <= '0;
            fit_h <= '0;
            state <= S_PLACE;
          end else begin
            state <= S_MUL;
          end
        end

        S_MUL: begin
          quo     <= product;
          rem     <= '0;
          divisor <= calc_rw ? core_h : core_w;
          step    <= '0;
          state   <= S_DIV;
        end

        S_DIV: begin
          rem  <= trial_ok ? trial_diff[cbfp_pkg::DIM_W-1:0]
                           : trial_rem[cbfp_pkg::DIM_W-1:0];
          quo  <= {quo[cbfp_pkg::PROD_W-2:0], trial_ok};
          step <= step + cbfp_pkg::STEP_W'(1);
          if (step == cbfp_pkg::STEP_W'(cbfp_pkg::DIV_STEPS - 1)) begin
            state <= S_CHECK;
          end
        end

        S_CHECK: begin
          if (calc_rw) begin
            if (!second) begin
              // Tall core: height takes the full usable height first.
              fit_h <= area_h;
              if (q_over_w) begin
                fit_w  <= area_w;
                second <= 1'b1;
                state  <= S_MUL;
              end else begin
                fit_w <= quo[cbfp_pkg::DIM_W-1:0];
                state <= S_PLACE;
              end
            end else begin
              fit_w <= quo[cbfp_pkg::DIM_W-1:0];
              state <= S_PLACE;
            end
          end else begin
            if (!second) begin
              // Wide or square core: width takes the full usable width first.
              fit_w <= area_w;
              if (q_over_h) begin
                fit_h  <= area_h;
                second <= 1'b1;
                state  <= S_MUL;
              end else begin
                fit_h <= quo[cbfp_pkg::DIM_W-1:0];
                state <= S_PLACE;
              end
            end else begin
              fit_h <= quo[cbfp_pkg::DIM_W-1:0];
              state <= S_PLACE;
            end
          end
        end

        S_PLACE: begin
          // Wait here only while the previous result is still unread.
          if (!m_tvalid || m_tready) begin
            m_tvalid        <= 1'b1;
            m_tdata[11:0]   <= box_top;
            m_tdata[23:12]  <= box_left;
            m_tdata[36:24]  <= box_right;
            m_tdata[49:37]  <= box_bottom;
            m_tdata[62:50]  <= fit_w;
            m_tdata[75:63]  <= fit_h;
            m_tdata[88:76]  <= degen ? '0 : px_sum[cbfp_pkg::DIM_W-1:0];
            m_tdata[101:89] <= degen ? '0 : py_sum[cbfp_pkg::DIM_W-1:0];
            m_tdata[103:102] <= 2'b00;
            m_tuser         <= degen;
            state           <= S_PIX;
          end
        end

        default: state <= S_PIX;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // A degenerate result carries no fit and no placement.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      (m_tdata[101:50] == '0))
    else $error("degenerate result with nonzero fit or placement");

  // A good fit never exceeds the usable canvas.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |->
      (({1'b0, m_tdata[62:50]} + {2'b00, margin, 1'b0}) <= {1'b0, target_width}) &&
      (({1'b0, m_tdata[75:63]} + {2'b00, margin, 1'b0}) <= {1'b0, target_height}))
    else $error("fit size exceeds usable canvas");

  // The last pixel of a frame starts the fit sequence and stops pixel intake.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && frame_end) |=> !s_tready)
    else $error("pixel intake continued past end of frame");

  // A new result is never loaded over one that is still waiting.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready && (state == S_PLACE)) |=> (state == S_PLACE))
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

FILE: test/tb_content_bbox_fit_placer.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_content_bbox_fit_placer: self-checking bench of the content box placer
// Streams frames of pixels with random idling on both sides, predicts each
// frame's content box, fit size, placement and status, and compares every
// result field by field against that prediction.
// ============================================================================

module tb_content_bbox_fit_placer;

  // Anchor code one is the explicit centre; the package names no centre code.
  localparam logic [cbfp_pkg::MODE_W-1:0] PLACE_CENTRE = 4'd1;

  // The slowest result raises m_tvalid only after setup, two multiply and divide
  // passes, the check and placement, and may then wait out a receiver stall; a
  // sender gap is bounded by its random range and the settle pause by SETTLE_CYCLES.
  // No correct run goes anywhere near this many cycles without a request moving.
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 64;
  localparam int ITEM_COUNT = 1150;

  // One predicted result: the content box, the fitted size and its origin.
  typedef struct packed {
    logic [cbfp_pkg::CNT_W-1:0] top;
    logic [cbfp_pkg::CNT_W-1:0] left;
    logic [cbfp_pkg::DIM_W-1:0] right;
    logic [cbfp_pkg::DIM_W-1:0] bottom;
    logic [cbfp_pkg::DIM_W-1:0] fit_w;
    logic [cbfp_pkg::DIM_W-1:0] fit_h;
    logic [cbfp_pkg::DIM_W-1:0] pos_x;
    logic [cbfp_pkg::DIM_W-1:0] pos_y;
    logic                       status;
  } box_fit_t;

  // The scoreboard keeps its own copy of the registers and of the frame scan.
  // Every accepted pixel advances the scan; the last pixel of a frame queues
  // the expected result, which the receiver side pops and compares.
  class bbox_fit_scoreboard;
    int unsigned frame_w, frame_h, thresh, tgt_w, tgt_h, margin;
    logic [cbfp_pkg::MODE_W-1:0] mode;
    logic [3*cbfp_pkg::CHAN_W-1:0] bg;
    int unsigned row, col, min_row, max_row, min_col, max_col;
    bit seen;
    box_fit_t pending[$];
    int errors;

    function new();
      frame_w = 640;
      frame_h = 480;
      thresh = 10;
      tgt_w = 300;
      tgt_h = 200;
      margin = 10;
      mode = PLACE_CENTRE;
      bg = '0;
      errors = 0;
      start_frame();
    endfunction

    function void start_frame();
      row = 0;
      col = 0;
      min_row = 0;
      max_row = 0;
      min_col = 32'hFFFF_FFFF;
      max_col = 0;
      seen = 1'b0;
    endfunction

    function void set_reg(cbfp_pkg::reg_index_t idx, int unsigned val);
      case (idx)
        cbfp_pkg::REG_FRAME_WIDTH:   frame_w = val & 32'h1FFF;
        cbfp_pkg::REG_FRAME_HEIGHT:  frame_h = val & 32'h1FFF;
        cbfp_pkg::REG_THRESHOLD:     thresh = val & 32'hFF;
        cbfp_pkg::REG_TARGET_WIDTH:  tgt_w = val & 32'h1FFF;
        cbfp_pkg::REG_TARGET_HEIGHT: tgt_h = val & 32'h1FFF;
        cbfp_pkg::REG_MARGIN:        margin = val & 32'h7FF;
        cbfp_pkg::REG_PLACE_MODE:    mode = val[cbfp_pkg::MODE_W-1:0];
        default: ;
      endcase
    endfunction

    // A zero frame size scans as one, anything past MAX_DIM as MAX_DIM.
    function int unsigned eff_dim(int unsigned v);
      if (v == 0) return 1;
      if (v > cbfp_pkg::MAX_DIM) return cbfp_pkg::MAX_DIM;
      return v;
    endfunction

    function int unsigned chan_gap(logic [cbfp_pkg::CHAN_W-1:0] a,
                                   logic [cbfp_pkg::CHAN_W-1:0] b);
      return (a > b) ? int'(a - b) : int'(b - a);
    endfunction

    function void note_pixel(logic [cbfp_pkg::CHAN_W-1:0] c0,
                             logic [cbfp_pkg::CHAN_W-1:0] c1,
                             logic [cbfp_pkg::CHAN_W-1:0] c2);
      int unsigned w, h;
      bit hit;
      box_fit_t r;
      longint tp, lf, rt, bt, cw, ch, aw, ah, rw, rh, sx, sy, px, py;
      w = eff_dim(frame_w);
      h = eff_dim(frame_h);
      if (row == 0 && col == 0) bg = {c0, c1, c2};
      hit = chan_gap(bg[23:16], c0) >= thresh || chan_gap(bg[15:8], c1) >= thresh ||
            chan_gap(bg[7:0], c2) >= thresh;
      if (hit) begin
        if (!seen) begin
          min_row = row;
          min_col = col;
          max_col = col;
          seen = 1'b1;
        end
        max_row = row;
        if (col < min_col) min_col = col;
        if (col > max_col) max_col = col;
      end
      // Row and frame ends use "at or beyond", so a width or height that
      // shrank in the middle of a frame closes the row or frame at once.
      if (col < w - 1) begin
        col++;
        return;
      end
      if (row < h - 1) begin
        col = 0;
        row++;
        return;
      end

      tp = seen ? min_row : 0;
      lf = seen ? min_col : 0;
      rt = seen ? max_col : w;
      bt = seen ? max_row : h;
      cw = rt - lf;
      ch = bt - tp;
      aw = longint'(tgt_w) - 2 * longint'(margin);
      ah = longint'(tgt_h) - 2 * longint'(margin);
      rw = 0;
      rh = 0;
      px = 0;
      py = 0;
      r.status = 1'b0;
      if (cw <= 0 || ch <= 0 || aw <= 0 || ah <= 0) begin
        r.status = 1'b1;
      end else begin
        // Fill the axis the core is longer along, then back off if the
        // other axis overflows the usable area.
        if (ch > cw) begin
          rh = ah;
          rw = rh * cw / ch;
          if (rw > aw) begin
            rw = aw;
            rh = rw * ch / cw;
          end
        end else begin
          rw = aw;
          rh = rw * ch / cw;
          if (rh > ah) begin
            rh = ah;
            rw = rh * cw / ch;
          end
        end
        sx = aw - rw;
        sy = ah - rh;
        case (mode)
          cbfp_pkg::PLACE_TOP:          begin px = sx / 2; py = 0;      end
          cbfp_pkg::PLACE_BOTTOM:       begin px = sx / 2; py = sy;     end
          cbfp_pkg::PLACE_LEFT:         begin px = 0;      py = sy / 2; end
          cbfp_pkg::PLACE_RIGHT:        begin px = sx;     py = sy / 2; end
          cbfp_pkg::PLACE_TOP_LEFT:     begin px = 0;      py = 0;      end
          cbfp_pkg::PLACE_TOP_RIGHT:    begin px = sx;     py = 0;      end
          cbfp_pkg::PLACE_BOTTOM_LEFT:  begin px = 0;      py = sy;     end
          cbfp_pkg::PLACE_BOTTOM_RIGHT: begin px = sx;     py = sy;     end
          default:                      begin px = sx / 2; py = sy / 2; end
        endcase
        px += margin;
        py += margin;
      end
      r.top = tp[cbfp_pkg::CNT_W-1:0];
      r.left = lf[cbfp_pkg::CNT_W-1:0];
      r.right = rt[cbfp_pkg::DIM_W-1:0];
      r.bottom = bt[cbfp_pkg::DIM_W-1:0];
      r.fit_w = rw[cbfp_pkg::DIM_W-1:0];
      r.fit_h = rh[cbfp_pkg::DIM_W-1:0];
      r.pos_x = px[cbfp_pkg::DIM_W-1:0];
      r.pos_y = py[cbfp_pkg::DIM_W-1:0];
      pending.push_back(r);
      start_frame();
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [cbfp_pkg::OUT_W-1:0] d, logic st);
      box_fit_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t ns: result with no frame pending, expected none, actual %h",
                 $time, d);
        return;
      end
      want = pending.pop_front();
      compare("top_row",    16'(want.top),    16'(d[11:0]));
      compare("left_col",   16'(want.left),   16'(d[23:12]));
      compare("right_col",  16'(want.right),  16'(d[36:24]));
      compare("bottom_row", 16'(want.bottom), 16'(d[49:37]));
      compare("fit_width",  16'(want.fit_w),  16'(d[62:50]));
      compare("fit_height", 16'(want.fit_h),  16'(d[75:63]));
      compare("place_x",    16'(want.pos_x),  16'(d[88:76]));
      compare("place_y",    16'(want.pos_y),  16'(d[101:89]));
      compare("pad bits",   16'd0,            16'(d[103:102]));
      compare("status",     16'(want.status), 16'(st));
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_wr_en = 1'b0;
  logic [cbfp_pkg::IDX_W-1:0]    cfg_index = '0;
  logic [cbfp_pkg::CFG_W-1:0]    cfg_data = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [cbfp_pkg::IN_W-1:0]     s_tdata = '0;   // chan0, chan1, chan2 from bit 0
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [cbfp_pkg::OUT_W-1:0]    m_tdata;        // top_row, left_col, right_col,
                                                 // bottom_row, fit_width,
                                                 // fit_height, place_x, place_y, pad
  logic                          m_tuser;        // status

  bbox_fit_scoreboard sb = new();
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int pixels_sent = 0;
  int quiet_cycles = 0;

  content_bbox_fit_placer i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // The enable drops for a cycle between register writes so that it never
  // gets two assignments in one step.
  task automatic write_reg(input cbfp_pkg::reg_index_t idx, input int unsigned val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[cbfp_pkg::CFG_W-1:0];
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic config_all(input int unsigned fw, input int unsigned fh,
                            input int unsigned thr, input int unsigned tw,
                            input int unsigned th, input int unsigned mg,
                            input int unsigned md);
    write_reg(cbfp_pkg::REG_FRAME_WIDTH, fw);
    write_reg(cbfp_pkg::REG_FRAME_HEIGHT, fh);
    write_reg(cbfp_pkg::REG_THRESHOLD, thr);
    write_reg(cbfp_pkg::REG_TARGET_WIDTH, tw);
    write_reg(cbfp_pkg::REG_TARGET_HEIGHT, th);
    write_reg(cbfp_pkg::REG_MARGIN, mg);
    write_reg(cbfp_pkg::REG_PLACE_MODE, md);
  endtask

  // One pixel request. A gap drawn per pixel holds tvalid low first; with no
  // gap tvalid simply stays high for the next request.
  task automatic send_pixel(input logic [cbfp_pkg::CHAN_W-1:0] c0,
                            input logic [cbfp_pkg::CHAN_W-1:0] c1,
                            input logic [cbfp_pkg::CHAN_W-1:0] c2);
    int gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {c2, c1, c0};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    sb.note_pixel(c0, c1, c2);
    pixels_sent++;
  endtask

  // The sender holds off until every queued result is back, then lets the
  // block settle for longer than its slowest fit sequence.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A channel close to the background one, landing on either side of the
  // threshold so that the content test is exercised right at its edge.
  function automatic logic [cbfp_pkg::CHAN_W-1:0] near_chan(logic [cbfp_pkg::CHAN_W-1:0] b,
                                                            int unsigned thr);
    int d, v;
    d = $urandom_range(0, thr + 1);
    v = $urandom_range(0, 1) ? int'(b) + d : int'(b) - d;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[cbfp_pkg::CHAN_W-1:0];
  endfunction

  // Whole frames at the current register setting. Most pixels sit near the
  // background; the rest are arbitrary colours, which mostly count as content.
  task automatic send_frames(input int n);
    int unsigned total;
    int unsigned rnd;
    logic [3*cbfp_pkg::CHAN_W-1:0] base;
    int kind;
    for (int f = 0; f < n; f++) begin
      total = sb.eff_dim(sb.frame_w) * sb.eff_dim(sb.frame_h);
      rnd = $urandom();
      case ($urandom_range(0, 7))
        0:       base = '0;
        1:       base = '1;
        default: base = rnd[3*cbfp_pkg::CHAN_W-1:0];
      endcase
      send_pixel(base[23:16], base[15:8], base[7:0]);
      for (int unsigned k = 1; k < total; k++) begin
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
          send_pixel(near_chan(base[23:16], sb.thresh), near_chan(base[15:8], sb.thresh),
                     near_chan(base[7:0], sb.thresh));
        end else begin
          send_pixel(cbfp_pkg::CHAN_W'($urandom_range(0, 255)),
                     cbfp_pkg::CHAN_W'($urandom_range(0, 255)),
                     cbfp_pkg::CHAN_W'($urandom_range(0, 255)));
        end
      end
      // Now and then the sender waits for the result before the next frame.
      if ($urandom_range(0, 7) == 0) wait_for_results();
    end
  endtask

  function automatic int unsigned pick_frame_dim();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return $urandom_range(9, 24);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  function automatic int unsigned pick_canvas_dim();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 8191);
      1:       return $urandom_range(1, 60);
      default: return $urandom_range(60, 600);
    endcase
  endfunction

  // Receiver: draws a stall per result, then holds tready high until a
  // result is taken and checks it against the oldest prediction.
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 12) : 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (m_tvalid !== 1'b1) @(posedge clk);
      sb.check_result(m_tdata, m_tuser);
    end
  end

  // Any request on either stream or a register write counts as progress.
  always @(posedge clk) begin
    if (rst || cfg_wr_en || (s_tvalid && s_tready === 1'b1) ||
        (m_tvalid === 1'b1 && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int phase;
    int unsigned thr, mg;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The first frame keeps the reset values of threshold,
    // canvas, margin and anchor; only the frame size is made small.
    write_reg(cbfp_pkg::REG_FRAME_WIDTH, 3);
    write_reg(cbfp_pkg::REG_FRAME_HEIGHT, 2);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd9);
    send_pixel(8'd0, 8'd10, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
    wait_for_results();

    // Threshold zero: every pixel is content, the background pixel too.
    config_all(3, 2, 0, 4096, 1, 0, cbfp_pkg::PLACE_TOP_LEFT);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd0);
    wait_for_results();

    // Zero width scans as one column; a full-scale difference at the top
    // threshold is content, and a one-column core is degenerate.
    write_reg(cbfp_pkg::REG_THRESHOLD, 255);
    write_reg(cbfp_pkg::REG_FRAME_WIDTH, 0);
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    wait_for_results();

    // A margin wider than half the canvas leaves no usable area.
    config_all(2, 2, 10, 300, 300, 2047, PLACE_CENTRE);
    send_pixel(8'd10, 8'd10, 8'd10);
    send_pixel(8'd0, 8'd10, 8'd10);
    send_pixel(8'd10, 8'd10, 8'd10);
    send_pixel(8'd10, 8'd10, 8'd255);
    wait_for_results();

    // A frame with no content reports the whole frame as its box.
    config_all(1, 1, 10, 1, 8191, 0, cbfp_pkg::PLACE_BOTTOM_RIGHT);
    send_pixel(8'd128, 8'd64, 8'd32);
    wait_for_results();

    // Frame size shrunk in the middle of a frame: the next pixel is already
    // past the new row and frame end, so the frame closes on it.
    config_all(4, 3, 20, 200, 100, 5, cbfp_pkg::PLACE_TOP_RIGHT);
    send_pixel(8'd50, 8'd50, 8'd50);
    send_pixel(8'd50, 8'd50, 8'd50);
    send_pixel(8'd90, 8'd50, 8'd50);
    send_pixel(8'd50, 8'd50, 8'd50);
    send_pixel(8'd50, 8'd50, 8'd50);
    send_pixel(8'd50, 8'd50, 8'd200);
    wait_for_results();
    write_reg(cbfp_pkg::REG_FRAME_WIDTH, 2);
    write_reg(cbfp_pkg::REG_FRAME_HEIGHT, 1);
    send_pixel(8'd50, 8'd50, 8'd50);
    wait_for_results();

    // Random part. Each phase rewrites every register and streams a few
    // frames; the anchor walks through all sixteen codes.
    phase = 0;
    while (pixels_sent < ITEM_COUNT || phase < 16) begin
      case ($urandom_range(0, 5))
        0:       thr = 0;
        1:       thr = 255;
        2:       thr = $urandom_range(0, 255);
        default: thr = $urandom_range(1, 40);
      endcase
      case ($urandom_range(0, 7))
        0:       mg = 0;
        1:       mg = 2047;
        2:       mg = $urandom_range(0, 2047);
        default: mg = $urandom_range(0, 40);
      endcase
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      config_all(pick_frame_dim(), pick_frame_dim(), thr, pick_canvas_dim(),
                 pick_canvas_dim(), mg, phase % 16);
      send_frames($urandom_range(1, 3));
      wait_for_results();
      phase++;
    end

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
